// File: rtl/core/mpe_pkg.sv
// Shared types and constants for the matrix polynomial evaluator.
`timescale 1ns / 1ps

package mpe_pkg;

    // Default sizing
    localparam int MPE_MAX_DIM    = 8;
    localparam int MPE_MAX_DEGREE = 15;
    localparam int MPE_FRAC_BITS  = 16;

    // Request codes
    localparam logic [1:0] REQ_LOAD_ELEM = 2'd0;
    localparam logic [1:0] REQ_LOAD_COEF = 2'd1;
    localparam logic [1:0] REQ_RUN       = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MATRIX_DIM  = 1'b0;
    localparam logic CFG_POLY_DEGREE = 1'b1;

    // Saturation bounds, 48-bit signed
    localparam logic signed [47:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SAT_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic        [1:0]  req_type;
        logic        [2:0]  row;
        logic        [2:0]  col;
        logic signed [31:0] elem_value;
        logic        [3:0]  coeff_index;
        logic signed [15:0] coeff_value;
    } t_in;

    typedef struct packed {
        logic        [2:0]  out_row;
        logic        [2:0]  out_col;
        logic signed [47:0] result_value;
        logic               last;
        logic               overflow;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_TM_RD,
        S_TM_MUL,
        S_TM_ADD,
        S_MUL_RD,
        S_MUL_PP,
        S_MUL_ACC,
        S_MUL_WR,
        S_CP_RD,
        S_CP_WR,
        S_OUT_RD,
        S_OUT_WAIT
    } t_state;

endpackage

// File: rtl/core/matrix_polynomial_evaluator.sv
// Matrix polynomial evaluator: sequencer, matrix memories and MAC datapath.
`timescale 1ns / 1ps
// Loads are stored as accepted; a transaction is accepted whenever the block is idle.
// A run initialises the power and sum memories and adds the first term; per further
// degree it multiplies on one shared multiply-accumulate that reads the power and
// source memories, copies back and adds a term; results leave via an output register.
// Reset (synchronous, active low) clears control, dim=1, degree=0; memories are not cleared.

module matrix_polynomial_evaluator
    import mpe_pkg::*;
#(
    parameter int MAX_DIM    = MPE_MAX_DIM,
    parameter int MAX_DEGREE = MPE_MAX_DEGREE,
    parameter int FRAC_BITS  = MPE_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NCELL = MAX_DIM * MAX_DIM;
    localparam int AW    = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int NCOEF = MAX_DEGREE + 1;
    localparam int DW    = (NCOEF > 1) ? $clog2(NCOEF) : 1;
    localparam int ACC_W = 81 + IW;

    // Memories
    logic signed [31:0] m_src  [NCELL];
    logic signed [15:0] m_coef [NCOEF];
    logic signed [47:0] m_pow  [NCELL];
    logic signed [47:0] m_nxt  [NCELL];
    logic signed [47:0] m_sum  [NCELL];

    logic signed [31:0] r_src_q;
    logic signed [15:0] r_coef_q;
    logic signed [47:0] r_pow_q, r_nxt_q, r_sum_q;

    t_state r_state, n_state;
    logic [3:0]    r_dim, r_deg;
    logic [IW-1:0] r_nm1, r_r, r_c, r_k;
    logic [DW-1:0] r_dm, r_i;
    logic          r_ovf;
    logic signed [56:0]      r_pp_lo;
    logic signed [55:0]      r_pp_hi;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [63:0]      r_term;
    logic       r_ovalid;
    t_out       r_out;

    logic          accept, is_run, last_rc, k_last, out_load;
    logic [AW-1:0] addr_x, addr_rk, addr_kc;
    int            n_clamp, d_clamp;

    assign accept  = i_in_valid && o_in_ready;
    assign is_run  = i_in_data.req_type == REQ_RUN;
    assign last_rc = (r_r == r_nm1) && (r_c == r_nm1);
    assign k_last  = r_k == r_nm1;
    assign out_load = (r_state == S_OUT_WAIT) && (!r_ovalid || i_out_ready);
    assign addr_x  = AW'(int'(r_r) * MAX_DIM + int'(r_c));
    assign addr_rk = AW'(int'(r_r) * MAX_DIM + int'(r_k));
    assign addr_kc = AW'(int'(r_k) * MAX_DIM + int'(r_c));

    // Clamp run size from the configuration
    always_comb begin
        n_clamp = int'(r_dim);
        if (n_clamp == 0) n_clamp = 1;
        if (n_clamp > MAX_DIM) n_clamp = MAX_DIM;
        d_clamp = int'(r_deg);
        if (d_clamp > MAX_DEGREE) d_clamp = MAX_DEGREE;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (accept && is_run) n_state = S_INIT;
            S_INIT:    if (last_rc) n_state = S_TM_RD;
            S_TM_RD:   n_state = S_TM_MUL;
            S_TM_MUL:  n_state = S_TM_ADD;
            S_TM_ADD: begin
                if (!last_rc) n_state = S_TM_RD;
                else if (r_i == r_dm) n_state = S_OUT_RD;
                else n_state = S_MUL_RD;
            end
            S_MUL_RD:  n_state = S_MUL_PP;
            S_MUL_PP:  n_state = S_MUL_ACC;
            S_MUL_ACC: n_state = k_last ? S_MUL_WR : S_MUL_RD;
            S_MUL_WR:  n_state = last_rc ? S_CP_RD : S_MUL_RD;
            S_CP_RD:   n_state = S_CP_WR;
            S_CP_WR:   n_state = last_rc ? S_TM_RD : S_CP_RD;
            S_OUT_RD:  n_state = S_OUT_WAIT;
            S_OUT_WAIT: if (out_load) n_state = last_rc ? S_IDLE : S_OUT_RD;
            default:   n_state = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_in_ready  = r_state == S_IDLE;
        o_out_valid = r_ovalid;
        o_out_data  = r_out;
    end

    // Datapath helpers
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [47:0]      prod_sat, term_sat, sum_sat;
    logic                    prod_ov, term_ov, sum_ov;
    logic signed [48:0]      sum_ext;

    always_comb begin
        acc_sh  = r_acc >>> FRAC_BITS;
        prod_ov = !((&acc_sh[ACC_W-1:47]) || !(|acc_sh[ACC_W-1:47]));
        prod_sat = prod_ov ? (acc_sh[ACC_W-1] ? SAT_MIN : SAT_MAX) : acc_sh[47:0];
        term_ov = !((&r_term[63:47]) || !(|r_term[63:47]));
        term_sat = term_ov ? (r_term[63] ? SAT_MIN : SAT_MAX) : r_term[47:0];
        sum_ext = {term_sat[47], term_sat} + {r_sum_q[47], r_sum_q};
        sum_ov  = sum_ext[48] != sum_ext[47];
        sum_sat = sum_ov ? (sum_ext[48] ? SAT_MIN : SAT_MAX) : sum_ext[47:0];
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.req_type == REQ_LOAD_ELEM
            && int'(i_in_data.row) < MAX_DIM && int'(i_in_data.col) < MAX_DIM) begin
            m_src[AW'(int'(i_in_data.row) * MAX_DIM + int'(i_in_data.col))]
                <= i_in_data.elem_value;
        end
        if (accept && i_in_data.req_type == REQ_LOAD_COEF
            && int'(i_in_data.coeff_index) <= MAX_DEGREE) begin
            m_coef[DW'(i_in_data.coeff_index)] <= i_in_data.coeff_value;
        end
        if (r_state == S_MUL_RD) begin
            r_src_q <= m_src[addr_kc];
            r_pow_q <= m_pow[addr_rk];
        end
        if (r_state == S_TM_RD) begin
            r_pow_q  <= m_pow[addr_x];
            r_coef_q <= m_coef[r_i];
        end
        if (r_state == S_TM_RD || r_state == S_OUT_RD) r_sum_q <= m_sum[addr_x];
        if (r_state == S_CP_RD) r_nxt_q <= m_nxt[addr_x];
        if (r_state == S_INIT) begin
            m_pow[addr_x] <= (r_r == r_c) ? (48'sd1 <<< FRAC_BITS) : 48'sd0;
            m_sum[addr_x] <= 48'sd0;
        end
        if (r_state == S_CP_WR) m_pow[addr_x] <= r_nxt_q;
        if (r_state == S_TM_ADD) m_sum[addr_x] <= sum_sat;
        if (r_state == S_MUL_WR) m_nxt[addr_x] <= prod_sat;
    end

    // Arithmetic registers
    always_ff @(posedge i_clk) begin
        r_pp_lo <= $signed({1'b0, r_pow_q[23:0]}) * r_src_q;
        r_pp_hi <= $signed(r_pow_q[47:24]) * r_src_q;
        r_term  <= r_coef_q * r_pow_q;
        if (r_state == S_INIT || r_state == S_MUL_WR) begin
            r_acc <= '0;
        end else if (r_state == S_MUL_ACC) begin
            r_acc <= r_acc + (ACC_W'(r_pp_hi) <<< 24) + ACC_W'(r_pp_lo);
        end
        if (out_load) begin
            r_out.out_row      <= 3'(r_r);
            r_out.out_col      <= 3'(r_c);
            r_out.result_value <= r_sum_q;
            r_out.last         <= last_rc;
            r_out.overflow     <= r_ovf;
        end
    end

    // Control registers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dim    <= 4'd1;
            r_deg    <= 4'd0;
            r_nm1    <= '0;
            r_dm     <= '0;
            r_r      <= '0;
            r_c      <= '0;
            r_k      <= '0;
            r_i      <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MATRIX_DIM) r_dim <= i_cfg_data;
                if (i_cfg_index == CFG_POLY_DEGREE) r_deg <= i_cfg_data;
            end
            // drop the output once taken, hold while stalled
            if (out_load) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
            // latch run size, restart counters
            if (r_state == S_IDLE && accept && is_run) begin
                r_nm1 <= IW'(n_clamp - 1);
                r_dm  <= DW'(d_clamp);
                r_r   <= '0;
                r_c   <= '0;
                r_k   <= '0;
                r_i   <= '0;
                r_ovf <= 1'b0;
            end
            // advance the entry walk
            if (r_state == S_INIT || r_state == S_TM_ADD || r_state == S_MUL_WR
                || r_state == S_CP_WR || out_load) begin
                if (r_c == r_nm1) begin
                    r_c <= '0;
                    r_r <= (r_r == r_nm1) ? '0 : r_r + 1'b1;
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
            if (r_state == S_TM_ADD && last_rc && r_i != r_dm) r_i <= r_i + 1'b1;
            if (r_state == S_MUL_ACC) r_k <= k_last ? '0 : r_k + 1'b1;
            // sticky saturation flag
            if (r_state == S_TM_ADD && (term_ov || sum_ov)) r_ovf <= 1'b1;
            if (r_state == S_MUL_WR && prod_ov) r_ovf <= 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= r_nm1)
        else $error("MAC index past matrix size");
    a_ovf_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INIT |-> !r_ovf)
        else $error("overflow flag not cleared at run start");
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_WAIT && n_state == S_IDLE) |=> r_out.last)
        else $error("run ended without last entry");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_ACC) |-> !o_in_ready)
        else $error("input accepted during a run");
`endif

endmodule

// File: tb/sv/mpe_checker.sv
// Transaction monitor, matrix polynomial predictor and result comparator.
`timescale 1ns / 1ps

module mpe_checker
    import mpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in        i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out       i_out_data,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    logic        [3:0]  dim_reg;
    logic        [3:0]  deg_reg;
    logic signed [31:0] src_mat [64];
    logic signed [15:0] coef_tab [16];
    logic signed [47:0] pow_mat [64];
    logic signed [47:0] nxt_mat [64];
    logic signed [47:0] acc_mat [64];
    logic               sat_seen;
    t_out               entry_queue [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Clamp a wide signed value to 48 bits, note saturation
    function automatic logic signed [47:0] clamp48(input logic signed [95:0] v);
        if (v > $signed(96'(SAT_MAX)) && v > 0) begin
            sat_seen = 1'b1;
            return SAT_MAX;
        end
        if (v < -(96'sd1 <<< 47)) begin
            sat_seen = 1'b1;
            return SAT_MIN;
        end
        return v[47:0];
    endfunction

    // Evaluate the polynomial and queue the N*N entries in row-major order
    task automatic evaluate_poly();
        int                 n, d;
        logic signed [95:0] acc, lhs, rhs;
        logic signed [95:0] term, tot;
        logic signed [47:0] tval;
        t_out               e;
        n = (dim_reg == 0) ? 1 : (dim_reg > MPE_MAX_DIM) ? MPE_MAX_DIM : int'(dim_reg);
        d = int'(deg_reg);
        sat_seen = 1'b0;
        for (int x = 0; x < 64; x++) begin
            acc_mat[x] = '0;
            pow_mat[x] = '0;
        end
        for (int r = 0; r < n; r++) pow_mat[r * 8 + r] = 48'sd1 <<< MPE_FRAC_BITS;
        for (int i = 0; i <= d; i++) begin
            if (i > 0) begin
                for (int r = 0; r < n; r++) begin
                    for (int c = 0; c < n; c++) begin
                        acc = '0;
                        for (int k = 0; k < n; k++) begin
                            lhs = pow_mat[r * 8 + k];
                            rhs = src_mat[k * 8 + c];
                            acc = acc + lhs * rhs;
                        end
                        nxt_mat[r * 8 + c] = clamp48(acc >>> MPE_FRAC_BITS);
                    end
                end
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++) pow_mat[r * 8 + c] = nxt_mat[r * 8 + c];
            end
            for (int r = 0; r < n; r++) begin
                for (int c = 0; c < n; c++) begin
                    lhs  = coef_tab[i];
                    rhs  = pow_mat[r * 8 + c];
                    term = lhs * rhs;
                    tval = clamp48(term);
                    lhs  = acc_mat[r * 8 + c];
                    rhs  = tval;
                    tot  = lhs + rhs;
                    acc_mat[r * 8 + c] = clamp48(tot);
                end
            end
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                e.out_row      = 3'(r);
                e.out_col      = 3'(c);
                e.result_value = acc_mat[r * 8 + c];
                e.last         = (r == n - 1) && (c == n - 1);
                e.overflow     = sat_seen;
                entry_queue    = {entry_queue, e};
            end
        end
    endtask

    // Track configuration, predict on input transactions, compare output transactions
    always @(posedge i_clk) begin
        t_out exp_e;
        if (!i_rst_n) begin
            dim_reg  = 4'd1;
            deg_reg  = 4'd0;
            sat_seen = 1'b0;
            entry_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MATRIX_DIM) dim_reg = i_cfg_data;
                else deg_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.req_type)
                    REQ_LOAD_ELEM: begin
                        src_mat[{i_in_data.row, i_in_data.col}] = i_in_data.elem_value;
                    end
                    REQ_LOAD_COEF: begin
                        coef_tab[i_in_data.coeff_index] = i_in_data.coeff_value;
                    end
                    REQ_RUN: begin
                        evaluate_poly();
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (entry_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_data);
                    o_fail_count++;
                end else begin
                    exp_e = entry_queue.pop_front();
                    if (exp_e.out_row !== i_out_data.out_row ||
                        exp_e.out_col !== i_out_data.out_col ||
                        exp_e.result_value !== i_out_data.result_value ||
                        exp_e.last !== i_out_data.last ||
                        exp_e.overflow !== i_out_data.overflow) begin
                        $display("%0t: mismatch expected r%0d c%0d v%0d l%0b o%0b",
                                 $time, exp_e.out_row, exp_e.out_col,
                                 exp_e.result_value, exp_e.last, exp_e.overflow);
                        $display("%0t:          actual   r%0d c%0d v%0d l%0b o%0b",
                                 $time, i_out_data.out_row, i_out_data.out_col,
                                 i_out_data.result_value, i_out_data.last,
                                 i_out_data.overflow);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = entry_queue.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the matrix polynomial evaluator testbench: clock, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import mpe_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out       o_out_data;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [3:0] i_cfg_data;
    int         fail_count;
    int         pending;

    bit         calm;
    bit         hold_req;
    logic [3:0] cur_dim;
    logic [3:0] cur_deg;
    bit         elem_loaded [64];
    bit         coef_loaded [16];

    matrix_polynomial_evaluator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    mpe_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #500ms;
        $display("matrix_polynomial_evaluator verification failed");
        $finish;
    end

    // Result receiver: random back-pressure plus one long hold on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                for (int k = 0; k < 3000; k++) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready = calm || ($urandom_range(99) >= 26);
        end
    end

    function automatic t_in make_req(logic [1:0] rt, logic [2:0] r, logic [2:0] c,
                                     logic [31:0] ev, logic [3:0] ci, logic [15:0] cv);
        t_in t;
        t.req_type    = rt;
        t.row         = r;
        t.col         = c;
        t.elem_value  = ev;
        t.coeff_index = ci;
        t.coeff_value = cv;
        return t;
    endfunction

    // Offer one transaction after an optional gap, hold until accepted
    task automatic send_req(t_in t);
        while (!calm && $urandom_range(99) < 26) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (t.req_type == REQ_LOAD_ELEM) elem_loaded[{t.row, t.col}] = 1'b1;
        if (t.req_type == REQ_LOAD_COEF) coef_loaded[t.coeff_index] = 1'b1;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic load_elem(int r, int c, logic [31:0] v);
        send_req(make_req(REQ_LOAD_ELEM, 3'(r), 3'(c), v, 4'($urandom), 16'($urandom)));
    endtask

    task automatic load_coef(int i, logic [15:0] v);
        send_req(make_req(REQ_LOAD_COEF, 3'($urandom), 3'($urandom), $urandom, 4'(i), v));
    endtask

    function automatic logic [31:0] pick_elem();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($signed($urandom_range(262144)) - 131072);
    endfunction

    function automatic logic [15:0] pick_coef();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(20)) - 10);
    endfunction

    // Fill any store entries the run will read, then issue the run
    task automatic start_run();
        int n;
        n = (cur_dim == 0) ? 1 : (cur_dim > 8) ? 8 : int'(cur_dim);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!elem_loaded[r * 8 + c]) load_elem(r, c, pick_elem());
        for (int i = 0; i <= cur_deg; i++)
            if (!coef_loaded[i]) load_coef(i, pick_coef());
        send_req(make_req(REQ_RUN, 3'($urandom), 3'($urandom), $urandom,
                          4'($urandom), 16'($urandom)));
    endtask

    // Write a register only once the block is drained
    task automatic write_cfg(logic idx, logic [3:0] val);
        i_in_valid = 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        for (int k = 0; k < 20; k++) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_MATRIX_DIM) cur_dim = val;
        else cur_deg = val;
    endtask

    initial begin
        int sel;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MATRIX_DIM;
        i_cfg_data  = 4'd0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        cur_dim     = 4'd1;
        cur_deg     = 4'd0;
        for (int k = 0; k < 10; k++) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: reset settings, field extremes, ignored code, odd dimensions
        load_elem(0, 0, 32'h7FFF_FFFF);
        load_coef(0, 16'h7FFF);
        start_run();
        load_coef(0, 16'h8000);
        start_run();
        send_req(make_req(2'd3, 3'd7, 3'd7, 32'h8000_0000, 4'd15, 16'h8000));
        write_cfg(CFG_POLY_DEGREE, 4'd15);
        load_elem(0, 0, 32'h8000_0000);
        load_coef(15, 16'h7FFF);
        start_run();
        write_cfg(CFG_MATRIX_DIM, 4'd0);
        start_run();
        write_cfg(CFG_POLY_DEGREE, 4'd2);
        write_cfg(CFG_MATRIX_DIM, 4'd15);
        load_elem(7, 7, 32'h0001_0000);
        start_run();
        write_cfg(CFG_MATRIX_DIM, 4'd8);
        write_cfg(CFG_POLY_DEGREE, 4'd0);
        start_run();

        // Random phase
        for (int it = 0; it < 360; it++) begin
            calm = (it >= 150 && it < 230);
            if (it == 100) hold_req = 1'b1;
            if (it == 200) begin
                wait (pending == 0);
                @(negedge i_clk);
            end
            sel = $urandom_range(99);
            if (sel < 6) begin
                if ($urandom_range(6) == 0) write_cfg(CFG_MATRIX_DIM, 4'($urandom));
                else write_cfg(CFG_MATRIX_DIM, 4'($urandom_range(3, 1)));
                if ($urandom_range(6) == 0) write_cfg(CFG_POLY_DEGREE, 4'($urandom));
                else write_cfg(CFG_POLY_DEGREE, 4'($urandom_range(4)));
            end else if (sel < 45) begin
                load_elem($urandom_range(7), $urandom_range(7), pick_elem());
            end else if (sel < 70) begin
                load_coef($urandom_range(15), pick_coef());
            end else if (sel < 95) begin
                start_run();
            end else begin
                send_req(make_req(2'd3, 3'($urandom), 3'($urandom), $urandom,
                                  4'($urandom), 16'($urandom)));
            end
        end
        i_in_valid = 1'b0;
        calm = 1'b0;

        // Drain and settle
        wait (pending == 0);
        for (int k = 0; k < 100; k++) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("matrix_polynomial_evaluator verification clean");
        end else begin
            $display("matrix_polynomial_evaluator verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mpe_pkg.sv
rtl/core/matrix_polynomial_evaluator.sv
tb/sv/mpe_checker.sv
tb/sv/testbench.sv
